### hdl/assert_macros.svh
// Assertion macros shared by the baud divisor calculator RTL.
// Each macro expands to one labeled concurrent assertion that is disabled while its reset argument is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bdc_pkg.sv
// Shared types and constants for the baud divisor calculator.
// No dependencies; imported by every module of the block.
package bdc_pkg;

   localparam int unsigned RATE_WIDTH  = 24;
   localparam int unsigned CLOCK_WIDTH = 32;
   localparam int unsigned VALUE_WIDTH = 16;
   localparam int unsigned MODE_WIDTH  = 3;
   localparam int unsigned ADDR_WIDTH  = 3;
   // One quotient bit is resolved per divider stage.
   localparam int unsigned DIV_STEPS   = 32;

   localparam logic [CLOCK_WIDTH-1:0] CLOCK_RESET = 32'd48000000;

   // Register index taken from the word address.
   localparam logic REG_REF_CLOCK = 1'b0;

   // Oversampling codes.
   localparam logic [MODE_WIDTH-1:0] MODE_16X = 3'h0;
   localparam logic [MODE_WIDTH-1:0] MODE_8X  = 3'h2;
   localparam logic [MODE_WIDTH-1:0] MODE_3X  = 3'h4;

   // Payload carried through the divider pipeline.
   typedef struct packed {
      logic [CLOCK_WIDTH-1:0] rem;
      logic [CLOCK_WIDTH-1:0] quo;
      logic [MODE_WIDTH-1:0]  mode;
      logic                   unsup;
   } div_data_type;

   // Write strobe and data from the register port to the register itself.
   typedef struct packed {
      logic                   wr_en;
      logic [CLOCK_WIDTH-1:0] wr_data;
   } csr_write_type;

endpackage

### hdl/bdc_csr.sv
// APB-style configuration port holding the reference clock register.
// Depends on bdc_pkg.
module bdc_csr
   import bdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CLOCK_WIDTH-1:0] csr_pwdata,
   output logic [CLOCK_WIDTH-1:0] csr_prdata,
   output logic                   csr_pready,
   output logic [CLOCK_WIDTH-1:0] ref_clock
);

   csr_write_type wr;
   logic [CLOCK_WIDTH-1:0] ref_clock_ff;
   logic                   reg_index;

   // Byte address 4*i selects register i; the low two bits are ignored.
   assign reg_index = csr_paddr[2];

   always_comb begin
      wr.wr_en   = csr_psel && csr_penable && csr_pwrite && (reg_index == REG_REF_CLOCK);
      wr.wr_data = csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= CLOCK_RESET;
      end else if (wr.wr_en) begin
         ref_clock_ff <= wr.wr_data;
      end
   end

   always_comb begin
      if (reg_index == REG_REF_CLOCK) begin
         csr_prdata = ref_clock_ff;
      end else begin
         csr_prdata = '0;
      end
   end

   assign csr_pready = 1'b1;
   assign ref_clock  = ref_clock_ff;

endmodule

### hdl/bdc_select.sv
// Entry stage: picks the oversampling factor and seeds the divider.
// Depends on bdc_pkg.
module bdc_select
   import bdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CLOCK_WIDTH-1:0] ref_clock,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [RATE_WIDTH-1:0]  in_rate,
   output logic                   out_valid,
   input  logic                   out_ready,
   output div_data_type           out_data
);

   logic         valid_ff;
   div_data_type data_ff;
   div_data_type data_in;

   logic [CLOCK_WIDTH-1:0] prod16;
   logic [CLOCK_WIDTH-1:0] prod8;
   logic [CLOCK_WIDTH-1:0] prod3;
   logic                   clock_zero;

   always_comb begin
      prod16     = {4'd0, in_rate, 4'd0};
      prod8      = {5'd0, in_rate, 3'd0};
      prod3      = {8'd0, in_rate} + {7'd0, in_rate, 1'b0};
      clock_zero = (ref_clock == '0);
   end

   // The remainder must start below the divisor; an exact fit gives a quotient
   // of 2^32, whose low 32 bits are all zero, so the remainder starts at zero.
   always_comb begin
      data_in.quo = '0;
      priority if (clock_zero) begin
         data_in.rem   = '0;
         data_in.mode  = MODE_16X;
         data_in.unsup = 1'b1;
      end else if (prod16 <= ref_clock) begin
         data_in.rem   = (prod16 == ref_clock) ? '0 : prod16;
         data_in.mode  = MODE_16X;
         data_in.unsup = 1'b0;
      end else if (prod8 <= ref_clock) begin
         data_in.rem   = (prod8 == ref_clock) ? '0 : prod8;
         data_in.mode  = MODE_8X;
         data_in.unsup = 1'b0;
      end else if (prod3 <= ref_clock) begin
         data_in.rem   = (prod3 == ref_clock) ? '0 : prod3;
         data_in.mode  = MODE_3X;
         data_in.unsup = 1'b0;
      end else begin
         data_in.rem   = '0;
         data_in.mode  = MODE_16X;
         data_in.unsup = 1'b1;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/bdc_div_stage.sv
// One restoring division step: resolves a single quotient bit per stage.
// Depends on bdc_pkg.
module bdc_div_stage
   import bdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CLOCK_WIDTH-1:0] divisor,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  div_data_type           in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output div_data_type           out_data
);

   logic         valid_ff;
   div_data_type data_ff;
   div_data_type data_in;

   logic [CLOCK_WIDTH:0] shifted;
   logic [CLOCK_WIDTH:0] diff;
   logic                 fits;

   // The remainder stays below the divisor, so the shifted value fits in
   // one extra bit and the difference fits back into the remainder width.
   always_comb begin
      shifted      = {in_data.rem, 1'b0};
      diff         = shifted - {1'b0, divisor};
      fits         = (shifted >= {1'b0, divisor});
      data_in      = in_data;
      data_in.rem  = fits ? diff[CLOCK_WIDTH-1:0] : shifted[CLOCK_WIDTH-1:0];
      data_in.quo  = {in_data.quo[CLOCK_WIDTH-2:0], fits};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/baud_divisor_calculator_core.sv
// Baud divisor calculator: one result per request, through factor select,
// 32 restoring division stages and an output register. Throughput is one
// request per cycle while the output is not stalled; the divider resolves one
// quotient bit per stage. Stalls back up stage by stage, filling bubbles.
// Synchronous reset empties the pipeline and loads the reference clock with
// 48 MHz; reset needs no clearing pass.
`include "assert_macros.svh"

module baud_divisor_calculator_core
   import bdc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [RATE_WIDTH-1:0]  req_baud_rate,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_baud_value,
   output logic [MODE_WIDTH-1:0]  rsp_sample_mode,
   output logic                   rsp_unsupported,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CLOCK_WIDTH-1:0] csr_pwdata,
   output logic [CLOCK_WIDTH-1:0] csr_prdata,
   output logic                   csr_pready
);

   logic [CLOCK_WIDTH-1:0] ref_clock;

   // Index 0 is the select stage output, index DIV_STEPS the last divider stage.
   logic         stage_valid [DIV_STEPS+1];
   logic         stage_ready [DIV_STEPS+1];
   div_data_type stage_data  [DIV_STEPS+1];

   logic                   out_valid_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic [MODE_WIDTH-1:0]  out_mode_ff;
   logic                   out_unsup_ff;
   logic [VALUE_WIDTH-1:0] out_value_in;
   logic [CLOCK_WIDTH-1:0] scale;
   logic                   out_in_ready;

   bdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ref_clock   (ref_clock)
   );

   bdc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .ref_clock (ref_clock),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_rate   (req_baud_rate),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      bdc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .divisor   (ref_clock),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // The quotient's low 32 bits suffice: 2^32 minus the ratio, modulo 2^32,
   // already wraps the exact-fit and zero-rate cases to a value of zero.
   always_comb begin
      scale = '0 - stage_data[DIV_STEPS].quo;
      if (stage_data[DIV_STEPS].unsup) begin
         out_value_in = '0;
      end else begin
         out_value_in = scale[CLOCK_WIDTH-1:CLOCK_WIDTH-VALUE_WIDTH];
      end
   end

   assign out_in_ready          = !out_valid_ff || rsp_ready;
   assign stage_ready[DIV_STEPS] = out_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_in_ready) begin
         out_valid_ff <= stage_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_in_ready && stage_valid[DIV_STEPS]) begin
         out_value_ff <= out_value_in;
         out_mode_ff  <= stage_data[DIV_STEPS].mode;
         out_unsup_ff <= stage_data[DIV_STEPS].unsup;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_baud_value  = out_value_ff;
   assign rsp_sample_mode = out_mode_ff;
   assign rsp_unsupported = out_unsup_ff;

   `ASSERT_IMPLIES(a_unsup_zero, clock, reset, rsp_valid && rsp_unsupported,
      (rsp_baud_value == '0) && (rsp_sample_mode == MODE_16X),
      "unsupported transaction carries nonzero fields")
   `ASSERT_IMPLIES(a_mode_code, clock, reset, rsp_valid,
      (rsp_sample_mode == MODE_16X) || (rsp_sample_mode == MODE_8X)
         || (rsp_sample_mode == MODE_3X),
      "illegal oversampling code")
   `ASSERT_IMPLIES(a_ready_empty, clock, reset, !rsp_valid, req_ready,
      "request stalled while output register is empty")
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid,
      "result present right after reset")

endmodule
